/* design/md5_pkg.sv */
// MD5 digest unit package: widths, initial chaining values, round tables and helpers.
// Used by the front queue, the engine and the top level. No dependencies.
package md5_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int BLOCK_WORDS = 16;
   localparam int WORD_W      = 32;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_SLOT = 6'd55;

   localparam logic [31:0] IV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

   typedef struct packed {
      logic       is_finish;
      logic [7:0] data;
   } md5_item_type;

   typedef struct packed {
      logic         valid;
      md5_item_type item;
   } md5_queue_type;

   function automatic logic [31:0] k_add(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] idx);
      logic [4:0] s;
      case ({idx[5:4], idx[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] msg_index(input logic [5:0] idx);
      logic [3:0] i;
      logic [3:0] g;
      i = idx[3:0];
      case (idx[5:4])
         2'd0:    g = i;
         2'd1:    g = (i << 2) + i + 4'd1;
         2'd2:    g = (i << 1) + i + 4'd5;
         2'd3:    g = (i << 3) - i;
         default: g = i;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] tmp;
      tmp = {v, v} << s;
      return tmp[63:32];
   endfunction

endpackage

/* design/md5_req_if.sv */
// Request channel of the MD5 digest unit: valid/ready plus one request word.
// No dependencies.
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

/* design/md5_rsp_if.sv */
// Response channel of the MD5 digest unit: valid/ready plus one digest word.
// No dependencies.
interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

/* design/md5_message_digest_unit.sv */
// MD5 digest unit top: a data word passes through the front queue, and a full 64-byte block then
// holds the engine for a fetch step, 64 rounds at one per cycle and a chain fold.
// Finish: mark, zero and length pad bytes, one or two block compressions, then 4 digest words.
// Sustained rate: 1 byte per cycle while the queue holds data, between compressions.
// Reset (synchronous, active high) clears the queue, counters and length and loads the
// initial chaining values; the block RAM is not cleared.
module md5_message_digest_unit #(
   parameter int QueueDepth = md5_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   md5_req_if.sink   req_chan,
   md5_rsp_if.source rsp_chan
);
   import md5_pkg::*;

   md5_queue_type queue;
   logic          pop;

   md5_front #(
      .QueueDepth (QueueDepth)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .queue    (queue)
   );

   md5_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .queue    (queue),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule

/* design/md5_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module md5_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/md5_front.sv */
// Front of the MD5 digest unit: accepts request words, tags them, queues them.
// Depends on md5_pkg and md5_req_if.
module md5_front #(
   parameter int QueueDepth = md5_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   md5_req_if.sink               req_chan,
   input  logic                  pop,
   output md5_pkg::md5_queue_type queue
);
   import md5_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   md5_item_type   slot_ff [QueueDepth];
   md5_item_type   item;
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, do_pop;

   assign req_chan.ready = (count_ff != CntW'(QueueDepth));
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (count_ff != '0);

   always_comb begin
      item.is_finish = req_chan.req_type;
      item.data      = req_chan.req_type ? 8'h00 : req_chan.data_byte;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   assign queue.valid = (count_ff != '0);
   assign queue.item  = slot_ff[rd_ptr_ff];
endmodule

/* design/md5_engine.sv */
// Back end of the MD5 digest unit: block buffer, padding, 64-round compression, digest out.
// Depends on md5_pkg, md5_ram and md5_rsp_if.
module md5_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  md5_pkg::md5_queue_type queue,
   output logic                  pop,
   md5_rsp_if.source             rsp_chan
);
   import md5_pkg::*;

   localparam int AddrW = $clog2(BLOCK_WORDS);

   localparam logic [2:0] ST_ABSORB = 3'd0;
   localparam logic [2:0] ST_PAD    = 3'd1;
   localparam logic [2:0] ST_COMP   = 3'd2;
   localparam logic [2:0] ST_FOLD   = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   localparam logic [1:0] PH_MARK = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;

   logic [2:0]        state_ff, state_in;
   logic [5:0]        fill_ff, fill_in;
   logic [63:0]       bitlen_ff, bitlen_in;
   logic [63:0]       len_ff, len_in;
   logic [1:0]        phase_ff, phase_in;
   logic [2:0]        len_idx_ff, len_idx_in;
   logic              padding_ff, padding_in;
   logic              done_ff, done_in;
   logic [23:0]       word_ff, word_in;
   logic [31:0]       chain_ff [4];
   logic [31:0]       chain_in [4];
   logic [31:0]       va_ff, vb_ff, vc_ff, vd_ff;
   logic [31:0]       va_in, vb_in, vc_in, vd_in;
   logic [6:0]        round_ff, round_in;
   logic [1:0]        out_idx_ff, out_idx_in;

   logic              push_en;
   logic [7:0]        push_byte;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] msg_word;
   logic [5:0]        ridx;
   logic [31:0]       f_val, t_val;

   md5_ram #(
      .Width (WORD_W),
      .Depth (BLOCK_WORDS)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AddrW+1:2]),
      .wr_data (wr_data),
      .rd_addr (msg_index(round_ff[5:0])),
      .rd_data (msg_word)
   );

   assign ridx = round_ff[5:0] - 6'd1;

   always_comb begin
      case (ridx[5:4])
         2'd0:    f_val = (vb_ff & vc_ff) | (~vb_ff & vd_ff);
         2'd1:    f_val = (vb_ff & vd_ff) | (vc_ff & ~vd_ff);
         2'd2:    f_val = vb_ff ^ vc_ff ^ vd_ff;
         2'd3:    f_val = vc_ff ^ (vb_ff | ~vd_ff);
         default: f_val = 32'h0;
      endcase
      t_val = va_ff + f_val + msg_word + k_add(ridx);
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      bitlen_in  = bitlen_ff;
      len_in     = len_ff;
      phase_in   = phase_ff;
      len_idx_in = len_idx_ff;
      padding_in = padding_ff;
      done_in    = done_ff;
      word_in    = word_ff;
      chain_in   = chain_ff;
      va_in      = va_ff;
      vb_in      = vb_ff;
      vc_in      = vc_ff;
      vd_in      = vd_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;
      pop        = 1'b0;
      push_en    = 1'b0;
      push_byte  = 8'h00;
      wr_en      = 1'b0;
      wr_data    = {push_byte, word_ff};

      case (state_ff)
         ST_ABSORB: begin
            if (queue.valid) begin
               pop = 1'b1;
               if (queue.item.is_finish) begin
                  len_in     = bitlen_ff;
                  padding_in = 1'b1;
                  phase_in   = PH_MARK;
                  len_idx_in = 3'd0;
                  state_in   = ST_PAD;
               end else begin
                  push_en   = 1'b1;
                  push_byte = queue.item.data;
                  bitlen_in = bitlen_ff + 64'd8;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            case (phase_ff)
               PH_MARK: begin
                  push_byte = PAD_MARK;
                  phase_in  = (fill_ff == LEN_SLOT) ? PH_LEN : PH_ZERO;
               end
               PH_ZERO: begin
                  push_byte = 8'h00;
                  if (fill_ff == LEN_SLOT) begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  push_byte  = len_ff[7:0];
                  len_in     = len_ff >> 8;
                  len_idx_in = len_idx_ff + 3'd1;
                  if (len_idx_ff == 3'd7) begin
                     done_in = 1'b1;
                  end
               end
               default: begin
                  push_en = 1'b0;
               end
            endcase
         end
         ST_COMP: begin
            round_in = round_ff + 7'd1;
            if (round_ff != 7'd0) begin
               va_in = vd_ff;
               vd_in = vc_ff;
               vc_in = vb_ff;
               vb_in = vb_ff + rotl32(t_val, rot_amount(ridx));
            end
            if (round_ff == 7'd64) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + va_ff;
            chain_in[1] = chain_ff[1] + vb_ff;
            chain_in[2] = chain_ff[2] + vc_ff;
            chain_in[3] = chain_ff[3] + vd_ff;
            if (done_ff) begin
               state_in = ST_OUT;
            end else if (padding_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_ABSORB;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               out_idx_in = out_idx_ff + 2'd1;
               if (out_idx_ff == 2'd3) begin
                  chain_in   = IV;
                  bitlen_in  = 64'd0;
                  padding_in = 1'b0;
                  done_in    = 1'b0;
                  state_in   = ST_ABSORB;
               end
            end
         end
         default: begin
            state_in = ST_ABSORB;
         end
      endcase

      if (push_en) begin
         wr_data = {push_byte, word_ff};
         case (fill_ff[1:0])
            2'd0:    word_in[7:0]   = push_byte;
            2'd1:    word_in[15:8]  = push_byte;
            2'd2:    word_in[23:16] = push_byte;
            2'd3:    wr_en          = 1'b1;
            default: wr_en          = 1'b0;
         endcase
         fill_in = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            state_in = ST_COMP;
            round_in = 7'd0;
            va_in    = chain_ff[0];
            vb_in    = chain_ff[1];
            vc_in    = chain_ff[2];
            vd_in    = chain_ff[3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ABSORB;
         fill_ff    <= 6'd0;
         bitlen_ff  <= 64'd0;
         phase_ff   <= PH_MARK;
         len_idx_ff <= 3'd0;
         padding_ff <= 1'b0;
         done_ff    <= 1'b0;
         chain_ff   <= IV;
         round_ff   <= 7'd0;
         out_idx_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         bitlen_ff  <= bitlen_in;
         phase_ff   <= phase_in;
         len_idx_ff <= len_idx_in;
         padding_ff <= padding_in;
         done_ff    <= done_in;
         chain_ff   <= chain_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      word_ff <= word_in;
      va_ff   <= va_in;
      vb_ff   <= vb_in;
      vc_ff   <= vc_in;
      vd_ff   <= vd_in;
   end

   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.digest_word = chain_ff[out_idx_ff];
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.last_word   = (out_idx_ff == 2'd3);
endmodule

/* design/md5_checker.sv */
// Port-level checks on the MD5 digest unit response channel, with its bind.
// Depends on md5_message_digest_unit and md5_rsp_if.
module md5_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_word,
   input logic [1:0]  rsp_index,
   input logic        rsp_last
);
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_index == 2'd3)))
      else $error("last flag does not match word index");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && (rsp_index == $past(rsp_index) + 2'd1)))
      else $error("digest words not back to back in order");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word) && $stable(rsp_index)))
      else $error("stalled digest word changed");
endmodule

bind md5_message_digest_unit md5_checker u_md5_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.digest_word),
   .rsp_index (rsp_chan.word_index),
   .rsp_last  (rsp_chan.last_word)
);

/* verif/testbench.sv */
// Testbench for md5_message_digest_unit: streams byte messages, predicts each digest word
// with its own MD5 model and checks every response word in order.
// Depends on md5_message_digest_unit, md5_req_if and md5_rsp_if from the design folder.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_beat_type;

   localparam logic [31:0] ROUND_ADD [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

   localparam int ROUND_SHIFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                       6, 10, 15, 21};

   localparam logic REQ_DATA   = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   logic clock;
   logic reset;

   md5_req_if req_chan ();
   md5_rsp_if rsp_chan ();

   md5_message_digest_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [31:0]     chain_words [4];
   logic [7:0]      block_bytes [64];
   int unsigned     block_fill;
   logic [63:0]     message_bits;
   digest_beat_type pending_digest_words [$];

   int  error_count;
   int  cycle_count;
   int  random_words;
   bit  req_gaps_on;
   bit  rsp_stalls_on;
   bit  rsp_enable;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   task automatic restart_digest();
      chain_words[0] = 32'h67452301;
      chain_words[1] = 32'hefcdab89;
      chain_words[2] = 32'h98badcfe;
      chain_words[3] = 32'h10325476;
      block_fill     = 0;
      message_bits   = '0;
   endtask

   task automatic fold_block();
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      int          g;
      for (int i = 0; i < 16; i++)
         m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = 5 * i + 1;
            end
            2: begin
               f = b ^ c ^ d;
               g = 3 * i + 5;
            end
            default: begin
               f = c ^ (b | ~d);
               g = 7 * i;
            end
         endcase
         t = a + f + m[g % 16] + ROUND_ADD[i];
         a = d;
         d = c;
         c = b;
         b = b + rotate_left(t, ROUND_SHIFT[(i / 16) * 4 + (i % 4)]);
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
   endtask

   task automatic absorb_byte(input logic [7:0] v);
      block_bytes[block_fill] = v;
      block_fill++;
      if (block_fill == 64) begin
         fold_block();
         block_fill = 0;
      end
   endtask

   task automatic predict_digest(input logic kind, input logic [7:0] value);
      logic [63:0]     bits;
      digest_beat_type beat;
      if (kind == REQ_DATA) begin
         absorb_byte(value);
         message_bits += 64'd8;
      end else begin
         bits = message_bits;
         absorb_byte(8'h80);
         while (block_fill != 56)
            absorb_byte(8'h00);
         for (int i = 0; i < 8; i++)
            absorb_byte(bits[8*i +: 8]);
         for (int i = 0; i < 4; i++) begin
            beat.word  = chain_words[i];
            beat.index = i[1:0];
            beat.last  = (i == 3);
            pending_digest_words.push_back(beat);
         end
         restart_digest();
      end
   endtask

   task automatic send_word(input logic kind, input logic [7:0] value);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= kind;
      req_chan.data_byte <= value;
      do @(posedge clock); while (!req_chan.ready);
      predict_digest(kind, value);
   endtask

   task automatic send_message(input int length);
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < length; i++)
         send_word(REQ_DATA, 8'($urandom_range(0, 255)));
      send_word(REQ_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // response side: random stall per word when stalls are on, in-order compare
   initial begin
      int              stall;
      digest_beat_type beat;
      wait (rsp_enable);
      forever begin
         stall = rsp_stalls_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (pending_digest_words.size() == 0) begin
            $error("unexpected digest word %h", rsp_chan.digest_word);
            error_count++;
         end else begin
            beat = pending_digest_words.pop_front();
            if (rsp_chan.digest_word !== beat.word) begin
               $error("digest_word expected %h actual %h", beat.word, rsp_chan.digest_word);
               error_count++;
            end
            if (rsp_chan.word_index !== beat.index) begin
               $error("word_index expected %0d actual %0d", beat.index, rsp_chan.word_index);
               error_count++;
            end
            if (rsp_chan.last_word !== beat.last) begin
               $error("last_word expected %0d actual %0d", beat.last, rsp_chan.last_word);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_message();
      send_message(0);
      send_message(0);
   endtask

   task automatic test_byte_extremes();
      req_gaps_on = 1'b0;
      send_word(REQ_DATA, 8'h00);
      send_word(REQ_FINISH, 8'hff);
      send_word(REQ_DATA, 8'hff);
      send_word(REQ_FINISH, 8'h00);
      send_word(REQ_DATA, 8'h55);
      send_word(REQ_DATA, 8'haa);
      send_word(REQ_FINISH, 8'h5a);
      send_message(3);
   endtask

   // lengths around the 56-byte length slot and the block edge
   task automatic test_pad_boundaries();
      int lengths [4] = '{55, 56, 63, 64};
      foreach (lengths[i]) begin
         send_message(lengths[i]);
         random_words += lengths[i] + 1;
      end
   endtask

   task automatic test_random_messages();
      int length;
      while (random_words < 380) begin
         length = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 20) : $urandom_range(21, 130);
         send_message(length);
         random_words += length + 1;
      end
   endtask

   initial begin
      error_count   = 0;
      cycle_count   = 0;
      random_words  = 0;
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      rsp_enable    = 1'b0;
      restart_digest();
      foreach (block_bytes[i])
         block_bytes[i] = 8'h00;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.req_type  <= REQ_DATA;
      req_chan.data_byte <= 8'h00;
      rsp_chan.ready     <= 1'b0;
      repeat (11) @(posedge clock);
      reset      <= 1'b0;
      rsp_enable = 1'b1;
      @(posedge clock);

      test_empty_message();
      test_byte_extremes();
      test_pad_boundaries();
      test_random_messages();

      req_chan.valid <= 1'b0;
      while (pending_digest_words.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
